@@ rtl/imc_pkg.sv @@
// Shared types, constants and tables for the IMU motion and posture classifier.
`timescale 1ns / 1ps
package imc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;
    localparam int XW                = 36;        // CORDIC x/y datapath width
    localparam int ZW                = 26;        // CORDIC angle accumulator width
    localparam int ONE_G             = 8192;
    localparam int DEG180            = 11796480;  // 180 deg in 2^-16 deg
    localparam int ANGLE_MAX         = 23040;     // 180 deg in 1/128 deg
    localparam int SQRT_STEPS        = 16;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_LOW_GRAVITY  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_IMPACT       = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SHAKE_RATE   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MOVING_RATE  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MOVING_DEV   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_TILT_ANGLE   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_AXIS_DOM     = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_STABLE_BAND  = 3'd7;

    localparam logic [15:0] RST_LOW_GRAVITY = 16'd2867;
    localparam logic [15:0] RST_IMPACT      = 16'd14746;
    localparam logic [15:0] RST_SHAKE_RATE  = 16'd11520;
    localparam logic [15:0] RST_MOVING_RATE = 16'd1600;
    localparam logic [15:0] RST_MOVING_DEV  = 16'd1475;
    localparam logic [14:0] RST_TILT_ANGLE  = 15'd6400;
    localparam logic [14:0] RST_AXIS_DOM    = 15'd6144;
    localparam logic [14:0] RST_STABLE_BAND = 15'd2048;

    localparam int FLAG_LOW_GRAVITY = 0;
    localparam int FLAG_IMPACT      = 1;
    localparam int FLAG_SHAKE       = 2;
    localparam int FLAG_MOVING      = 3;
    localparam int FLAG_TILTED      = 4;
    localparam int FLAG_STABLE      = 5;

    localparam logic [2:0] POSTURE_UNKNOWN   = 3'd0;
    localparam logic [2:0] POSTURE_UPRIGHT   = 3'd1;
    localparam logic [2:0] POSTURE_LIFTED    = 3'd2;
    localparam logic [2:0] POSTURE_FACE_DOWN = 3'd3;
    localparam logic [2:0] POSTURE_SIDE      = 3'd4;

    localparam logic [2:0] EVENT_NONE        = 3'd0;
    localparam logic [2:0] EVENT_STABLE      = 3'd1;
    localparam logic [2:0] EVENT_MOVING      = 3'd2;
    localparam logic [2:0] EVENT_TILTED      = 3'd3;
    localparam logic [2:0] EVENT_SHAKE       = 3'd4;
    localparam logic [2:0] EVENT_LOW_GRAVITY = 3'd5;
    localparam logic [2:0] EVENT_FACE_DOWN   = 3'd6;
    localparam logic [2:0] EVENT_IMPACT      = 3'd7;

    localparam logic [2:0] FACE_NONE         = 3'd0;
    localparam logic [2:0] FACE_NEUTRAL      = 3'd1;
    localparam logic [2:0] FACE_ATTENTIVE    = 3'd2;
    localparam logic [2:0] FACE_CONCERNED    = 3'd3;
    localparam logic [2:0] FACE_STARTLED     = 3'd4;

    typedef struct packed {
        logic [15:0] low_gravity_limit;
        logic [15:0] impact_limit;
        logic [15:0] shake_rate_limit;
        logic [15:0] moving_rate_limit;
        logic [15:0] moving_accel_deviation;
        logic [14:0] tilt_angle_limit;
        logic [14:0] axis_dominance_limit;
        logic [14:0] stable_band_half;
    } cfg_t;

    typedef struct packed {
        logic               context_valid;
        logic [5:0]         motion_flags;
        logic [2:0]         posture_code;
        logic [2:0]         event_code;
        logic [2:0]         face_code;
        logic [15:0]        accel_magnitude;
        logic [15:0]        rate_magnitude;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
    } result_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        case (idx)
            0:  return 26'sd2949120;
            1:  return 26'sd1740967;
            2:  return 26'sd919879;
            3:  return 26'sd466945;
            4:  return 26'sd234379;
            5:  return 26'sd117304;
            6:  return 26'sd58666;
            7:  return 26'sd29335;
            8:  return 26'sd14668;
            9:  return 26'sd7334;
            10: return 26'sd3667;
            11: return 26'sd1833;
            12: return 26'sd917;
            13: return 26'sd458;
            14: return 26'sd229;
            15: return 26'sd115;
            16: return 26'sd57;
            17: return 26'sd29;
            18: return 26'sd14;
            19: return 26'sd7;
            20: return 26'sd4;
            21: return 26'sd2;
            22: return 26'sd1;
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/imc_isqrt.sv @@
// Pipelined truncated integer square root, one result bit per stage.
`timescale 1ns / 1ps
module imc_isqrt
    import imc_pkg::*;
(
    input  logic        clk,
    input  logic        ce,
    input  logic [31:0] radicand,
    output logic [15:0] root
);

    logic [31:0] rem_reg [0:SQRT_STEPS-1];
    logic [31:0] res_reg [0:SQRT_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < SQRT_STEPS; i++)
        begin : g_step
            localparam logic [31:0] BIT = 32'd1 << (30 - 2 * i);
            logic [31:0] rem_in;
            logic [31:0] res_in;
            logic [31:0] trial;

            if (i == 0)
            begin : g_first
                assign rem_in = radicand;
                assign res_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign res_in = res_reg[i-1];
            end

            assign trial = res_in + BIT;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (rem_in >= trial)
                    begin
                        rem_reg[i] <= rem_in - trial;
                        res_reg[i] <= (res_in >> 1) + BIT;
                    end
                    else
                    begin
                        rem_reg[i] <= rem_in;
                        res_reg[i] <= res_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[SQRT_STEPS-1][15:0];

endmodule

@@ rtl/imc_cordic.sv @@
// Pipelined CORDIC vectoring atan2, angle out in 1/128 degree.
`timescale 1ns / 1ps
module imc_cordic
    import imc_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               ce,
    input  logic signed [16:0] y_in,
    input  logic signed [16:0] x_in,
    output logic signed [15:0] angle
);

    logic signed [XW-1:0] x_reg [0:STAGES];
    logic signed [XW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic                 zero_reg [0:STAGES];
    logic signed [15:0]   angle_reg;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] z_round;

    assign xs = {{(XW-31){x_in[16]}}, x_in, 14'b0};
    assign ys = {{(XW-31){y_in[16]}}, y_in, 14'b0};

    // left half plane: turn by 180 deg first
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= (y_in >= 0) ? ZW'(DEG180) : -ZW'(DEG180);
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + atan_entry(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    assign z_round = (z_reg[STAGES] + ZW'(256)) >>> 9;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (zero_reg[STAGES])
                angle_reg <= '0;
            else if (z_round > ZW'(ANGLE_MAX))
                angle_reg <= 16'(ANGLE_MAX);
            else if (z_round < -ZW'(ANGLE_MAX))
                angle_reg <= -16'(ANGLE_MAX);
            else
                angle_reg <= z_round[15:0];
        end
    end

    assign angle = angle_reg;

endmodule

@@ rtl/imc_classify.sv @@
// Threshold flags and posture / event / face priority, registered result.
`timescale 1ns / 1ps
module imc_classify
    import imc_pkg::*;
(
    input  logic               clk,
    input  logic               ce,
    input  cfg_t               cfg,
    input  logic               sample_valid,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic [15:0]        accel_magnitude,
    input  logic [15:0]        rate_magnitude,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pitch_angle,
    output result_t            result
);

    result_t             result_reg;
    logic signed [17:0]  amag_s;
    logic signed [17:0]  dev;
    logic [16:0]         dev_abs;
    logic signed [16:0]  roll_abs;
    logic signed [16:0]  pitch_abs;
    logic signed [16:0]  ax_abs;
    logic signed [16:0]  ay_abs;
    logic signed [16:0]  lim;
    logic signed [16:0]  tilt;
    logic signed [17:0]  band;
    logic lowg, impact, shake, moving, tilted, stable;
    logic [2:0] posture, event_c, face;

    always_comb
    begin
        amag_s    = $signed({2'b0, accel_magnitude});
        dev       = amag_s - 18'sd8192;
        dev_abs   = (dev < 0) ? 17'(-dev) : dev[16:0];
        roll_abs  = (roll_angle < 0) ? -17'(roll_angle) : 17'(roll_angle);
        pitch_abs = (pitch_angle < 0) ? -17'(pitch_angle) : 17'(pitch_angle);
        ax_abs    = (accel_x < 0) ? -17'(accel_x) : 17'(accel_x);
        ay_abs    = (accel_y < 0) ? -17'(accel_y) : 17'(accel_y);
        lim       = $signed({2'b0, cfg.axis_dominance_limit});
        tilt      = $signed({2'b0, cfg.tilt_angle_limit});
        band      = $signed({3'b0, cfg.stable_band_half});

        lowg   = accel_magnitude < cfg.low_gravity_limit;
        impact = accel_magnitude > cfg.impact_limit;
        shake  = (rate_magnitude > cfg.shake_rate_limit) || impact;
        moving = (rate_magnitude > cfg.moving_rate_limit)
              || (dev_abs > {1'b0, cfg.moving_accel_deviation});
        tilted = (roll_abs > tilt) || (pitch_abs > tilt);
        stable = !moving && (amag_s > 18'sd8192 - band) && (amag_s < 18'sd8192 + band);

        if (lowg)
        begin
            posture = POSTURE_LIFTED;
            event_c = EVENT_LOW_GRAVITY;
            face    = FACE_STARTLED;
        end
        else if (17'(accel_z) < -lim)
        begin
            posture = POSTURE_FACE_DOWN;
            event_c = EVENT_FACE_DOWN;
            face    = FACE_CONCERNED;
        end
        else if ((ax_abs > lim) || (ay_abs > lim))
        begin
            posture = POSTURE_SIDE;
            event_c = shake ? EVENT_SHAKE : EVENT_TILTED;
            face    = shake ? FACE_STARTLED : FACE_ATTENTIVE;
        end
        else
        begin
            posture = POSTURE_UPRIGHT;
            event_c = shake ? EVENT_SHAKE : (moving ? EVENT_MOVING : EVENT_STABLE);
            face    = shake ? FACE_STARTLED : (moving ? FACE_ATTENTIVE : FACE_NEUTRAL);
        end
        if (impact)
        begin
            event_c = EVENT_IMPACT;
            face    = FACE_STARTLED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (!sample_valid)
                result_reg <= '0;
            else
            begin
                result_reg.context_valid                 <= 1'b1;
                result_reg.motion_flags[FLAG_LOW_GRAVITY] <= lowg;
                result_reg.motion_flags[FLAG_IMPACT]      <= impact;
                result_reg.motion_flags[FLAG_SHAKE]       <= shake;
                result_reg.motion_flags[FLAG_MOVING]      <= moving;
                result_reg.motion_flags[FLAG_TILTED]      <= tilted;
                result_reg.motion_flags[FLAG_STABLE]      <= stable;
                result_reg.posture_code                  <= posture;
                result_reg.event_code                    <= event_c;
                result_reg.face_code                     <= face;
                result_reg.accel_magnitude               <= accel_magnitude;
                result_reg.rate_magnitude                <= rate_magnitude;
                result_reg.roll_angle                    <= roll_angle;
                result_reg.pitch_angle                   <= pitch_angle;
            end
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/imu_motion_posture_classifier_top.sv @@
// Top level: IMU motion and posture classifier pipeline with output skid stage.
//
// Input stream (s_*): one raw IMU sample per transfer; s_tdata carries the
// three accelerometer and three gyro axes, s_tuser the sample-valid flag.
// Output stream (m_*): one classification result per input sample, in order;
// m_tuser is the context-valid flag, m_tdata the flags, codes, magnitudes
// and angles. An invalid sample yields an all-zero result.
// Configuration: wr_en / wr_index / wr_data write one threshold register per
// cycle; change them only while the pipeline is empty.
// Throughput: one sample per cycle while the pipeline is not stalled (see Stall
// below). Path from input transfer to m_tvalid: squares, sums, 16 square root
// stages, the CORDIC pre-rotation, CORDIC_STAGES iterations, rounding,
// classification and the output register.
// Reset: all valid bits clear, thresholds return to their defaults.
// Stall: when m_tready is low the result is held and one more result can be
// caught in a skid register; only then does s_tready drop and the whole
// pipeline freeze without losing or repeating a sample.
`timescale 1ns / 1ps
module imu_motion_posture_classifier_top
    import imc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic              s_tuser,   // sample_valid
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // motion_flags, posture_code, event_code, face_code,
                                         // accel_magnitude, rate_magnitude, roll_angle,
                                         // pitch_angle, zero pad
    output logic              m_tuser,   // context_valid
    input  logic              wr_en,
    input  logic [CFG_IW-1:0] wr_index,
    input  logic [CFG_DW-1:0] wr_data
);

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int RAW_LEN    = SQRT_STEPS + CORDIC_LAT;
    localparam int LAT        = 2 + SQRT_STEPS + CORDIC_LAT + 1;

    typedef struct packed {
        logic               sv;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } raw_t;

    cfg_t    cfg_reg;
    logic    ce;
    logic    vld_reg [0:LAT-1];

    logic signed [15:0] in_ax, in_ay, in_az, in_gx, in_gy, in_gz;
    logic signed [31:0] p_ax, p_ay, p_az, p_gx, p_gy, p_gz;
    logic [31:0] sq_ax_reg, sq_ay_reg, sq_az_reg, sq_gx_reg, sq_gy_reg, sq_gz_reg;
    raw_t        raw1_reg;
    raw_t        raw2_reg;
    logic [31:0] asum_reg, gsum_reg, yzsum_reg;
    raw_t        raw_dly_reg [0:RAW_LEN-1];
    logic [15:0] amag, gmag, yzmag;
    logic [15:0] amag_dly_reg [0:CORDIC_LAT-1];
    logic [15:0] gmag_dly_reg [0:CORDIC_LAT-1];
    raw_t        raw_tap;
    raw_t        raw_end;
    logic signed [15:0] roll, pitch;
    result_t     pipe_res;

    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_gravity_limit      <= RST_LOW_GRAVITY;
            cfg_reg.impact_limit           <= RST_IMPACT;
            cfg_reg.shake_rate_limit       <= RST_SHAKE_RATE;
            cfg_reg.moving_rate_limit      <= RST_MOVING_RATE;
            cfg_reg.moving_accel_deviation <= RST_MOVING_DEV;
            cfg_reg.tilt_angle_limit       <= RST_TILT_ANGLE;
            cfg_reg.axis_dominance_limit   <= RST_AXIS_DOM;
            cfg_reg.stable_band_half       <= RST_STABLE_BAND;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LOW_GRAVITY: cfg_reg.low_gravity_limit      <= wr_data;
                CFG_IMPACT:      cfg_reg.impact_limit           <= wr_data;
                CFG_SHAKE_RATE:  cfg_reg.shake_rate_limit       <= wr_data;
                CFG_MOVING_RATE: cfg_reg.moving_rate_limit      <= wr_data;
                CFG_MOVING_DEV:  cfg_reg.moving_accel_deviation <= wr_data;
                CFG_TILT_ANGLE:  cfg_reg.tilt_angle_limit       <= wr_data[14:0];
                CFG_AXIS_DOM:    cfg_reg.axis_dominance_limit   <= wr_data[14:0];
                CFG_STABLE_BAND: cfg_reg.stable_band_half       <= wr_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid register is occupied
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign in_ax = s_tdata[15:0];
    assign in_ay = s_tdata[31:16];
    assign in_az = s_tdata[47:32];
    assign in_gx = s_tdata[63:48];
    assign in_gy = s_tdata[79:64];
    assign in_gz = s_tdata[95:80];

    assign p_ax = in_ax * in_ax;
    assign p_ay = in_ay * in_ay;
    assign p_az = in_az * in_az;
    assign p_gx = in_gx * in_gx;
    assign p_gy = in_gy * in_gy;
    assign p_gz = in_gz * in_gz;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_ax_reg <= p_ax;
            sq_ay_reg <= p_ay;
            sq_az_reg <= p_az;
            sq_gx_reg <= p_gx;
            sq_gy_reg <= p_gy;
            sq_gz_reg <= p_gz;
            raw1_reg  <= '{sv: s_tuser, ax: in_ax, ay: in_ay, az: in_az};

            yzsum_reg <= sq_ay_reg + sq_az_reg;
            asum_reg  <= sq_ax_reg + sq_ay_reg + sq_az_reg;
            gsum_reg  <= sq_gx_reg + sq_gy_reg + sq_gz_reg;
            raw2_reg  <= raw1_reg;

            raw_dly_reg[0] <= raw2_reg;
            for (int k = 1; k < RAW_LEN; k++)
                raw_dly_reg[k] <= raw_dly_reg[k-1];

            amag_dly_reg[0] <= amag;
            gmag_dly_reg[0] <= gmag;
            for (int k = 1; k < CORDIC_LAT; k++)
            begin
                amag_dly_reg[k] <= amag_dly_reg[k-1];
                gmag_dly_reg[k] <= gmag_dly_reg[k-1];
            end
        end
    end

    imc_isqrt u_sqrt_accel (.clk(clk), .ce(ce), .radicand(asum_reg),  .root(amag));
    imc_isqrt u_sqrt_rate  (.clk(clk), .ce(ce), .radicand(gsum_reg),  .root(gmag));
    imc_isqrt u_sqrt_yz    (.clk(clk), .ce(ce), .radicand(yzsum_reg), .root(yzmag));

    // sample fields lined up with the square root outputs (raw_tap) and the CORDIC outputs (raw_end)
    assign raw_tap = raw_dly_reg[SQRT_STEPS-1];
    assign raw_end = raw_dly_reg[RAW_LEN-1];

    imc_cordic #(.STAGES(CORDIC_STAGES)) u_roll
    (
        .clk   (clk),
        .ce    (ce),
        .y_in  (17'(raw_tap.ay)),
        .x_in  (17'(raw_tap.az)),
        .angle (roll)
    );

    imc_cordic #(.STAGES(CORDIC_STAGES)) u_pitch
    (
        .clk   (clk),
        .ce    (ce),
        .y_in  (-17'(raw_tap.ax)),
        .x_in  ($signed({1'b0, yzmag})),
        .angle (pitch)
    );

    imc_classify u_classify
    (
        .clk             (clk),
        .ce              (ce),
        .cfg             (cfg_reg),
        .sample_valid    (raw_end.sv),
        .accel_x         (raw_end.ax),
        .accel_y         (raw_end.ay),
        .accel_z         (raw_end.az),
        .accel_magnitude (amag_dly_reg[CORDIC_LAT-1]),
        .rate_magnitude  (gmag_dly_reg[CORDIC_LAT-1]),
        .roll_angle      (roll),
        .pitch_angle     (pitch),
        .result          (pipe_res)
    );

    // output register plus skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= vld_reg[LAT-1];
        end
        else if (ce && vld_reg[LAT-1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
            out_reg <= skid_valid_reg ? skid_reg : pipe_res;
        else if (ce && vld_reg[LAT-1])
            skid_reg <= pipe_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.context_valid;
    assign m_tdata  = {1'b0, out_reg.pitch_angle, out_reg.roll_angle,
                       out_reg.rate_magnitude, out_reg.accel_magnitude,
                       out_reg.face_code, out_reg.event_code,
                       out_reg.posture_code, out_reg.motion_flags};

endmodule

@@ rtl/imc_checker.sv @@
// Port-level checks for the IMU motion and posture classifier, bound to the top.
`timescale 1ns / 1ps
module imc_checker
    import imc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // invalid sample gives an all-zero result
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid sample with nonzero result");

    // impact overrides event and face
    a_impact: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tdata[FLAG_IMPACT]
        |-> m_tdata[11:9] == EVENT_IMPACT && m_tdata[14:12] == FACE_STARTLED)
        else $error("impact not reflected in event or face");

    // a valid context always has a known posture and never reports stable while moving
    a_posture: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser
        |-> m_tdata[8:6] != POSTURE_UNKNOWN
            && !(m_tdata[FLAG_STABLE] && m_tdata[FLAG_MOVING]))
        else $error("bad posture or stable with moving");

endmodule

bind imu_motion_posture_classifier_top imc_checker u_imc_checker (.*);
